/* design/cfq_pkg.sv */
`default_nettype none
package cfq_pkg;

    // Word width of the stored values.
    localparam int DATA_W        = 32;
    localparam int DEFAULT_DEPTH = 8;

    // Depth of the request queue between the front and the back.
    localparam int REQ_QDEPTH = 2;
    localparam int REQ_QPTR_W = $clog2(REQ_QDEPTH);
    localparam int REQ_QCNT_W = $clog2(REQ_QDEPTH + 1);

    // Command codes.
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_DUMP = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_POP_RD = 2'd1,
        S_DUMP   = 2'd2
    } t_state;

    // One queued request.
    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] value;
    } t_req;

endpackage
`default_nettype wire

/* design/circular_fifo_queue_unit.sv */
`default_nettype none
// Push and error results pass the request queue and the result register; pop results
// also pass the registered read of the entry memory. Dump: the first word as for a pop,
// then one word per cycle until the last. Throughput: one push per cycle while the back
// end is idle; a pop or a dump holds the back end until its last result is out.
// A two-entry request queue lets start be taken while the back end works; busy when full.
// Reset (synchronous, active low) empties the queue; results cannot be stalled.
module circular_fifo_queue_unit
    import cfq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    output logic                          o_busy,
    input  wire logic [1:0]               i_command,
    input  wire logic signed [DATA_W-1:0] i_push_value,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic signed [DATA_W-1:0]      o_data_out,
    output logic                          o_last
);

    logic req_valid;
    t_req req;
    logic req_pop;

    // Front end: takes and screens requests.
    cfq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_command    (i_command),
        .i_push_value (i_push_value),
        .o_busy       (o_busy),
        .o_req_valid  (req_valid),
        .o_req        (req),
        .i_req_pop    (req_pop)
    );

    // Back end: owns the ring storage and produces results.
    cfq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_pop   (req_pop),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_data_out  (o_data_out),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

/* design/cfq_front.sv */
`default_nettype none
module cfq_front
    import cfq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [1:0]               i_command,
    input  wire logic signed [DATA_W-1:0] i_push_value,
    output logic                          o_busy,
    output logic                          o_req_valid,
    output t_req                          o_req,
    input  wire logic                     i_req_pop
);

    t_req                  r_q [REQ_QDEPTH];
    logic [REQ_QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [REQ_QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [REQ_QCNT_W-1:0] r_cnt, n_cnt;
    logic                  accept;
    logic                  push_q;
    logic                  pop_q;

    // A request is taken whenever the queue has room; unused codes are dropped here.
    assign o_busy      = (r_cnt == REQ_QCNT_W'(REQ_QDEPTH));
    assign accept      = i_start && !o_busy;
    assign push_q      = accept && (i_command == CMD_PUSH || i_command == CMD_POP ||
                                    i_command == CMD_DUMP);
    assign pop_q       = i_req_pop && o_req_valid;
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push_q) begin
            n_wr_ptr = (r_wr_ptr == REQ_QPTR_W'(REQ_QDEPTH - 1)) ? '0
                                                                  : r_wr_ptr + 1'b1;
        end
        if (pop_q) begin
            n_rd_ptr = (r_rd_ptr == REQ_QPTR_W'(REQ_QDEPTH - 1)) ? '0
                                                                  : r_rd_ptr + 1'b1;
        end
        if (push_q && !pop_q) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_q && !push_q) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Request payload storage.
    always_ff @(posedge i_clk) begin
        if (push_q) begin
            r_q[r_wr_ptr] <= '{cmd: i_command, value: i_push_value};
        end
    end

endmodule
`default_nettype wire

/* design/cfq_back.sv */
`default_nettype none
module cfq_back
    import cfq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_req_valid,
    input  wire t_req                     i_req,
    output logic                          o_req_pop,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic signed [DATA_W-1:0]      o_data_out,
    output logic                          o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_state                  r_state, n_state;
    logic [AW-1:0]           r_head, n_head;
    logic [AW-1:0]           r_tail, n_tail;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_idx, n_idx;
    logic [CW-1:0]           r_left, n_left;
    logic                    r_out_valid, n_out_valid;
    t_status                 r_out_status, n_out_status;
    logic signed [DATA_W-1:0] r_out_data, n_out_data;
    logic                    r_out_last, n_out_last;
    logic                    mem_we;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic signed [DATA_W-1:0] r_rd_data;
    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic                    q_empty;
    logic                    q_full;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx);
        adv = (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign q_empty = (r_count == '0);
    assign q_full  = (r_count == CW'(DEPTH));

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && !q_empty) begin
                    if (i_req.cmd == CMD_POP) begin
                        n_state = S_POP_RD;
                    end else if (i_req.cmd == CMD_DUMP) begin
                        n_state = S_DUMP;
                    end
                end
            end
            S_POP_RD: n_state = S_IDLE;
            S_DUMP: begin
                if (r_left == CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath control and result generation.
    always_comb begin
        o_req_pop    = 1'b0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_head;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_idx        = r_idx;
        n_left       = r_left;
        n_out_valid  = 1'b0;
        n_out_status = ST_OK;
        n_out_data   = '0;
        n_out_last   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop = 1'b1;
                    priority if (i_req.cmd == CMD_PUSH) begin
                        n_out_valid = 1'b1;
                        n_out_last  = 1'b1;
                        if (q_full) begin
                            n_out_status = ST_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            n_tail  = adv(r_tail);
                            n_count = r_count + 1'b1;
                        end
                    end else if (q_empty) begin
                        // Pop or dump of an empty queue.
                        n_out_valid  = 1'b1;
                        n_out_last   = 1'b1;
                        n_out_status = ST_EMPTY;
                    end else begin
                        // Pop or dump: fetch the head word first.
                        rd_en  = 1'b1;
                        n_idx  = adv(r_head);
                        n_left = r_count;
                    end
                end
            end
            S_POP_RD: begin
                n_out_valid = 1'b1;
                n_out_data  = r_rd_data;
                n_out_last  = 1'b1;
                n_head      = adv(r_head);
                n_count     = r_count - 1'b1;
            end
            S_DUMP: begin
                n_out_valid = 1'b1;
                n_out_data  = r_rd_data;
                if (r_left == CW'(1)) begin
                    n_out_last = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx;
                    n_idx   = adv(r_idx);
                    n_left  = r_left - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload and walk index.
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
    end

    // Entry storage with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= i_req.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_data_out = r_out_data;
    assign o_last     = r_out_last;

    // The occupancy count never goes past the capacity.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("occupancy exceeds depth");

    // A write is never issued into a full queue.
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !q_full)
        else $error("write into full queue");

    // A result that is not the last one only comes out of a dump walk.
    a_mid_from_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> ($past(r_state) == S_DUMP))
        else $error("non-final result outside a dump");

    // A pop read is followed by exactly one pop result.
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_RD) |=> (r_out_valid && r_out_last))
        else $error("pop produced no result");

endmodule
`default_nettype wire

/* dv/circular_fifo_queue_unit_tb.sv */
`timescale 1ns / 100ps

module circular_fifo_queue_unit_tb;
    import cfq_pkg::*;

    localparam int QDEPTH       = DEFAULT_DEPTH;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 200;
    localparam int NUM_PHASES   = 4;
    localparam int MAX_GAP      = 40;
    localparam int TAIL_CYCLES  = QDEPTH + 6;
    localparam int REPORT_LIMIT = 10;

    // Command code that the block takes but ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One result of the queue.
    typedef struct packed {
        t_status            status;
        logic signed [31:0] data;
        logic               last;
    } t_result;

    // One directed request, with a typed-in result where it is obvious.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] word;
        logic        typed;
        t_status     status;
        logic [31:0] data;
    } t_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    logic [1:0]               i_command;
    logic signed [DATA_W-1:0] i_push_value;
    logic                     o_valid;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_data_out;
    logic                     o_last;

    // Shadow copy of the queue contents.
    logic signed [31:0] queue_words [QDEPTH];
    int                 head_ptr;
    int                 tail_ptr;
    int                 word_count;

    t_result predicted[$];
    t_result expected_results[$];
    t_row    directed_rows[$];
    t_result front_result;
    int      error_count;
    int      cycle_count;

    circular_fifo_queue_unit #(
        .DEPTH(QDEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_command   (i_command),
        .i_push_value(i_push_value),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_data_out  (o_data_out),
        .o_last      (o_last)
    );

    // Free-running clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_result make_result(input t_status st, input logic [31:0] d,
                                            input logic l);
        t_result r;
        r.status = st;
        r.data   = d;
        r.last   = l;
        return r;
    endfunction

    // Works out the results of one request and updates the shadow queue.
    function automatic void predict_queue_response(input logic [1:0] cmd,
                                                   input logic [31:0] word);
        int idx;
        int n;
        predicted.delete();
        if (cmd == CMD_PUSH) begin
            if (word_count >= QDEPTH) begin
                predicted.push_back(make_result(ST_FULL, 32'd0, 1'b1));
            end else begin
                queue_words[tail_ptr] = word;
                tail_ptr = (tail_ptr + 1) % QDEPTH;
                word_count++;
                predicted.push_back(make_result(ST_OK, 32'd0, 1'b1));
            end
        end else if (cmd == CMD_POP) begin
            if (word_count == 0) begin
                predicted.push_back(make_result(ST_EMPTY, 32'd0, 1'b1));
            end else begin
                predicted.push_back(make_result(ST_OK, queue_words[head_ptr], 1'b1));
                head_ptr = (head_ptr + 1) % QDEPTH;
                word_count--;
            end
        end else if (cmd == CMD_DUMP) begin
            if (word_count == 0) begin
                predicted.push_back(make_result(ST_EMPTY, 32'd0, 1'b1));
            end else begin
                idx = head_ptr;
                for (n = 0; n < word_count; n++) begin
                    predicted.push_back(make_result(ST_OK, queue_words[idx],
                                                    (n + 1 == word_count)));
                    idx = (idx + 1) % QDEPTH;
                end
            end
        end
    endfunction

    function automatic void add_row(input logic [1:0] cmd, input logic [31:0] word,
                                    input logic typed, input t_status st,
                                    input logic [31:0] d);
        t_row r;
        r.cmd    = cmd;
        r.word   = word;
        r.typed  = typed;
        r.status = st;
        r.data   = d;
        directed_rows.push_back(r);
    endfunction

    // Presents one request after a random idle gap and waits until it is taken.
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] word,
                                input logic typed, input t_status st,
                                input logic [31:0] d, input int idle_pct);
        int gap;
        gap = 0;
        while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_command    <= cmd;
        i_push_value <= word;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_queue_response(cmd, word);
        if (typed) begin
            expected_results.push_back(make_result(st, d, 1'b1));
        end else begin
            foreach (predicted[k]) expected_results.push_back(predicted[k]);
        end
    endtask

    // Holds off new requests until every outstanding result has come back.
    task automatic wait_for_drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Picks a random command: mostly fill-then-drain runs, some dumps and noise.
    function automatic logic [1:0] pick_command(inout logic filling);
        int r;
        if (word_count == QDEPTH && filling && $urandom_range(1) == 0) filling = 1'b0;
        if (word_count == 0 && !filling && $urandom_range(1) == 0) filling = 1'b1;
        r = $urandom_range(99);
        if (r < 3) return CMD_UNUSED;
        if (r < 13) return CMD_DUMP;
        if (r < 78) return filling ? CMD_PUSH : CMD_POP;
        return filling ? CMD_POP : CMD_PUSH;
    endfunction

    // Compares each result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result: status=%0d data=%h last=%b",
                             o_status, o_data_out, o_last);
            end else begin
                front_result = expected_results.pop_front();
                if (o_status !== front_result.status || o_data_out !== front_result.data ||
                    o_last !== front_result.last) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("mismatch: expected status=%0d data=%h last=%b,",
                                 front_result.status, front_result.data, front_result.last,
                                 " got status=%0d data=%h last=%b",
                                 o_status, o_data_out, o_last);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        int         phase;
        int         sent;
        int         idle_pct;
        logic [1:0] cmd;
        logic [31:0] word;
        logic       filling;

        error_count  = 0;
        cycle_count  = 0;
        head_ptr     = 0;
        tail_ptr     = 0;
        word_count   = 0;
        filling      = 1'b1;
        i_rst_n      <= 1'b0;
        i_start      <= 1'b0;
        i_command    <= CMD_PUSH;
        i_push_value <= '0;
        foreach (queue_words[k]) queue_words[k] = '0;

        // Edge cases: empty queue, extremes, full queue, wrap, ignored code.
        add_row(CMD_POP,    32'd0,        1'b1, ST_EMPTY, 32'd0);
        add_row(CMD_DUMP,   32'd0,        1'b1, ST_EMPTY, 32'd0);
        add_row(CMD_UNUSED, 32'd0,        1'b0, ST_OK,    32'd0);
        add_row(CMD_PUSH,   32'h7FFFFFFF, 1'b1, ST_OK,    32'd0);
        add_row(CMD_PUSH,   32'h80000000, 1'b1, ST_OK,    32'd0);
        add_row(CMD_PUSH,   32'h00000000, 1'b1, ST_OK,    32'd0);
        add_row(CMD_PUSH,   32'hFFFFFFFF, 1'b1, ST_OK,    32'd0);
        add_row(CMD_PUSH,   32'h00000001, 1'b1, ST_OK,    32'd0);
        add_row(CMD_PUSH,   32'h55555555, 1'b1, ST_OK,    32'd0);
        add_row(CMD_PUSH,   32'hAAAAAAAA, 1'b1, ST_OK,    32'd0);
        add_row(CMD_PUSH,   32'h12345678, 1'b1, ST_OK,    32'd0);
        add_row(CMD_PUSH,   32'h00000005, 1'b1, ST_FULL,  32'd0);
        add_row(CMD_DUMP,   32'd0,        1'b0, ST_OK,    32'd0);
        add_row(CMD_POP,    32'd0,        1'b1, ST_OK,    32'h7FFFFFFF);
        add_row(CMD_POP,    32'd0,        1'b1, ST_OK,    32'h80000000);
        add_row(CMD_PUSH,   32'hDEADBEEF, 1'b1, ST_OK,    32'd0);
        add_row(CMD_PUSH,   32'h0BADF00D, 1'b1, ST_OK,    32'd0);
        add_row(CMD_PUSH,   32'h00000007, 1'b1, ST_FULL,  32'd0);
        add_row(CMD_DUMP,   32'd0,        1'b0, ST_OK,    32'd0);
        add_row(CMD_UNUSED, 32'hFFFFFFFF, 1'b0, ST_OK,    32'd0);
        add_row(CMD_POP,    32'd0,        1'b0, ST_OK,    32'd0);
        add_row(CMD_POP,    32'd0,        1'b0, ST_OK,    32'd0);
        add_row(CMD_POP,    32'd0,        1'b0, ST_OK,    32'd0);
        add_row(CMD_DUMP,   32'd0,        1'b0, ST_OK,    32'd0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_request(directed_rows[k].cmd, directed_rows[k].word, directed_rows[k].typed,
                         directed_rows[k].status, directed_rows[k].data, 0);
        wait_for_drain();

        // Random phases: no idling, heavy sender gaps, light gaps, no idling again.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                1: begin
                    idle_pct = 78;
                end
                2: begin
                    idle_pct = 17;
                end
                default: begin
                    idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / NUM_PHASES) begin
                cmd = pick_command(filling);
                case ($urandom_range(15))
                    0: word = 32'h7FFFFFFF;
                    1: word = 32'h80000000;
                    default: word = $urandom;
                endcase
                send_request(cmd, word, 1'b0, ST_OK, 32'd0, idle_pct);
                if (cmd != CMD_UNUSED) sent++;
            end
            wait_for_drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* circular_fifo_queue_unit.f */
design/cfq_pkg.sv
design/cfq_front.sv
design/cfq_back.sv
design/circular_fifo_queue_unit.sv
dv/circular_fifo_queue_unit_tb.sv
